FILE: hw/rtl/mwbb_pkg.sv
// Shared types and constants for the moving-window Bollinger band core.
// Used by mwbb_div, mwbb_sqrt and the core under hw/rtl; depends on nothing else.
package mwbb_pkg;

	localparam int MAX_WINDOW_DEF = 32;
	localparam int PRICE_BITS_DEF = 24;
	localparam int FRAC_BITS_DEF  = 8;

	localparam int WIN_W   = 6;
	localparam int MULT_W  = 3;
	localparam int OUT_W   = 32;
	localparam int UP_W    = 26;
	localparam int LO_W    = 24;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [WIN_W-1:0]  WIN_RESET  = 6'd21;
	localparam logic [MULT_W-1:0] MULT_RESET = 3'd2;
	localparam logic [OUT_W-1:0]  WORD_MAX   = {OUT_W{1'b1}};
	localparam logic [UP_W-1:0]   UPPER_MAX  = {UP_W{1'b1}};
	localparam logic [LO_W-1:0]   LOWER_MAX  = {LO_W{1'b1}};

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_WINDOW = 1'b0,
		REG_MULT   = 1'b1
	} reg_idx_t;

	// status of a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

FILE: hw/rtl/mwbb_ring.sv
// Price history memory: one write port, one registered read port.
// Depends on nothing.
module mwbb_ring #(
	parameter int DEPTH  = 32,
	parameter int DATA_W = 24
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data
);
	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hw/rtl/mwbb_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on mwbb_pkg (unit_stat_t).
module mwbb_div #(
	parameter int DIVIDEND_W = 37,
	parameter int DIVISOR_W  = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [DIVIDEND_W-1:0]     dividend,
	input  logic [DIVISOR_W-1:0]      divisor,
	output logic [DIVIDEND_W-1:0]     quotient,
	output mwbb_pkg::unit_stat_t      stat
);
	import mwbb_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    shifted;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;

	always_comb begin
		shifted = {rem_q, quo_q[DIVIDEND_W-1]};
		diff    = shifted - {1'b0, dvs_q};
		ge      = shifted >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIVIDEND_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			rem_q <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: hw/rtl/mwbb_sqrt.sv
// Digit-serial integer square root, two radicand bits per cycle.
// Depends on mwbb_pkg (unit_stat_t).
module mwbb_sqrt #(
	parameter int ROOT_W = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2*ROOT_W-1:0]   radicand,
	output logic [ROOT_W-1:0]     root,
	output mwbb_pkg::unit_stat_t  stat
);
	import mwbb_pkg::*;

	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [2*ROOT_W-1:0] rad_q;
	logic [ROOT_W+1:0]   rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [ROOT_W+2:0]   cur;
	logic [ROOT_W+2:0]   trial;
	logic [ROOT_W+2:0]   sub;
	logic                ge;

	always_comb begin
		cur   = {rem_q[ROOT_W:0], rad_q[2*ROOT_W-1 -: 2]};
		sub   = {1'b0, root_q, 2'b01};
		trial = cur - sub;
		ge    = cur >= sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(ROOT_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[2*ROOT_W-3:0], 2'b00};
			rem_q  <= ge ? trial[ROOT_W+1:0] : cur[ROOT_W+1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign root      = root_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: hw/rtl/moving_window_bollinger_band_core.sv
// Moving-window Bollinger band core, sample standard deviation.
// A full-window word runs S_SQ, S_UPD, S_PREP, S_DIFF, S_DIV, S_ROOT, S_FIN, S_OUT.
// One word at a time, in_ready only in S_IDLE; variance divider and root take most time.
// A short (not yet full) window answers all zeros, going from S_UPD to S_OUT.
// Reset (async, active low) clears history and control, loads window 21, multiplier 2.
// The price memory is never cleared; entries are read only after being written.
module moving_window_bollinger_band_core #(
	parameter int MAX_WINDOW = mwbb_pkg::MAX_WINDOW_DEF,
	parameter int PRICE_BITS = mwbb_pkg::PRICE_BITS_DEF,
	parameter int FRAC_BITS  = mwbb_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB-style configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mwbb_pkg::PADDR_W-1:0]  paddr,
	input  logic [mwbb_pkg::PDATA_W-1:0]  pwdata,
	output logic [mwbb_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	// price input
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [PRICE_BITS-1:0]         close_price,
	// band output
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          window_full,
	output logic [mwbb_pkg::OUT_W-1:0]    mean_value,
	output logic [mwbb_pkg::OUT_W-1:0]    sigma_value,
	output logic [mwbb_pkg::UP_W-1:0]     upper_band,
	output logic [mwbb_pkg::LO_W-1:0]     lower_band
);
	import mwbb_pkg::*;

	localparam int AW    = $clog2(MAX_WINDOW);
	localparam int NW    = $clog2(MAX_WINDOW + 1);
	localparam int CMPW  = (WIN_W > NW) ? WIN_W : NW;
	localparam int SUMW  = PRICE_BITS + AW;         // running sum
	localparam int PPW   = 2 * PRICE_BITS;          // one squared price
	localparam int SQW   = 2 * PRICE_BITS + AW;     // running sum of squares
	localparam int SSW   = 2 * SUMW;                // sum squared
	localparam int DW    = NW + SQW;                // N * sumsq
	localparam int MW    = 2 * NW;                  // N * (N-1)
	localparam int VDW   = DW + 2 * FRAC_BITS;      // variance dividend
	localparam int RW    = PRICE_BITS + FRAC_BITS;  // root width
	localparam int VW    = 2 * RW;                  // scaled variance
	localparam int MDW   = SUMW + FRAC_BITS;        // mean dividend
	localparam int MSW   = MULT_W + OUT_W;          // multiplier * sigma
	localparam int BSW   = MSW + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_SQ, S_UPD, S_PREP, S_DIFF, S_DIV, S_ROOT, S_FIN, S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [WIN_W-1:0]  win_q;
	logic [MULT_W-1:0] mult_q;
	logic              cfg_wr;
	reg_idx_t          cfg_idx;

	// history
	logic [AW-1:0]   wp_q;
	logic [NW-1:0]   cnt_q;
	logic [SUMW-1:0] sum_q;
	logic [SQW-1:0]  sumsq_q;

	// per-word working registers
	logic [PRICE_BITS-1:0] p_q;
	logic [AW-1:0]         idx_q;
	logic                  full_q;
	logic [PRICE_BITS-1:0] old_s1;
	logic [PPW-1:0]        pp_s1;
	logic [PPW-1:0]        oo_s1;
	logic [DW-1:0]         nsq_s2;
	logic [SSW-1:0]        ss_s2;
	logic [MW-1:0]         m_s2;
	logic [OUT_W-1:0]      mean_s3;
	logic [OUT_W-1:0]      sigma_s3;
	logic [MSW-1:0]        ms_s3;

	// result waiting for the output register
	logic              res_full_q;
	logic [OUT_W-1:0]  res_mean_q;
	logic [OUT_W-1:0]  res_sigma_q;
	logic [UP_W-1:0]   res_up_q;
	logic [LO_W-1:0]   res_lo_q;

	// output register
	logic              out_valid_q;
	logic              out_full_q;
	logic [OUT_W-1:0]  out_mean_q;
	logic [OUT_W-1:0]  out_sigma_q;
	logic [UP_W-1:0]   out_up_q;
	logic [LO_W-1:0]   out_lo_q;

	// combinational helpers
	logic [CMPW-1:0]       win_ext;
	logic [NW-1:0]         w_eff;
	logic [AW-1:0]         idx_c;
	logic                  accept;
	logic                  out_load;
	logic [NW-1:0]         cnt_nxt;
	logic [NW-1:0]         idx_inc;
	logic [DW-1:0]         d_pos;
	logic [PRICE_BITS-1:0] rd_data;
	logic [MDW-1:0]        mean_quo;
	logic [VDW-1:0]        var_quo;
	logic [RW-1:0]         root;
	unit_stat_t            mean_stat;
	unit_stat_t            var_stat;
	unit_stat_t            root_stat;
	logic                  div_start;
	logic                  root_start;
	logic [OUT_W-1:0]      mean_c;
	logic [OUT_W-1:0]      sigma_c;
	logic [BSW-1:0]        up_sum;
	logic [BSW-1:0]        up_sh;
	logic [MSW-1:0]        lo_diff;
	logic [MSW-1:0]        lo_sh;
	logic [UP_W-1:0]       up_c;
	logic [LO_W-1:0]       lo_c;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_comb begin
		unique case (cfg_idx)
			REG_WINDOW: prdata = PDATA_W'(win_q);
			REG_MULT:   prdata = PDATA_W'(mult_q);
			default:    prdata = '0;
		endcase
	end

	// window length clamped to [2, MAX_WINDOW]
	always_comb begin
		win_ext = CMPW'(win_q);
		if (win_ext < CMPW'(2)) begin
			w_eff = NW'(2);
		end else if (win_ext > CMPW'(MAX_WINDOW)) begin
			w_eff = NW'(MAX_WINDOW);
		end else begin
			w_eff = NW'(win_ext);
		end
	end

	assign idx_c    = (NW'(wp_q) >= w_eff) ? '0 : wp_q;
	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);
	assign cnt_nxt  = full_q ? w_eff : cnt_q + NW'(1);
	assign idx_inc  = NW'(idx_q) + NW'(1);
	assign d_pos    = (nsq_s2 >= DW'(ss_s2)) ? nsq_s2 - DW'(ss_s2) : '0;

	assign div_start  = (state_q == S_DIFF);
	assign root_start = (state_q == S_DIV) && mean_stat.done && var_stat.done;

	mwbb_ring #(
		.DEPTH  (MAX_WINDOW),
		.DATA_W (PRICE_BITS)
	) u_ring (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (idx_c),
		.rd_data (rd_data),
		.wr_en   (state_q == S_UPD),
		.wr_addr (idx_q),
		.wr_data (p_q)
	);

	// mean = (sum << FRAC) / N
	mwbb_div #(
		.DIVIDEND_W (MDW),
		.DIVISOR_W  (NW)
	) u_mean_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({sum_q, {FRAC_BITS{1'b0}}}),
		.divisor  (w_eff),
		.quotient (mean_quo),
		.stat     (mean_stat)
	);

	// scaled variance = (d << 2*FRAC) / (N*(N-1))
	mwbb_div #(
		.DIVIDEND_W (VDW),
		.DIVISOR_W  (MW)
	) u_var_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({d_pos, {(2 * FRAC_BITS){1'b0}}}),
		.divisor  (m_s2),
		.quotient (var_quo),
		.stat     (var_stat)
	);

	mwbb_sqrt #(
		.ROOT_W (RW)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (var_quo[VW-1:0]),
		.root     (root),
		.stat     (root_stat)
	);

	// saturate mean and sigma to 32 bits
	always_comb begin
		if ({OUT_W'(0), mean_quo} > {MDW'(0), WORD_MAX}) begin
			mean_c = WORD_MAX;
		end else begin
			mean_c = OUT_W'(mean_quo);
		end
		if ({OUT_W'(0), root} > {RW'(0), WORD_MAX}) begin
			sigma_c = WORD_MAX;
		end else begin
			sigma_c = OUT_W'(root);
		end
	end

	// bands: upper saturates high, lower saturates at zero and at LOWER_MAX
	always_comb begin
		up_sum  = BSW'(mean_s3) + BSW'(ms_s3);
		up_sh   = up_sum >> FRAC_BITS;
		lo_diff = MSW'(mean_s3) - ms_s3;
		lo_sh   = lo_diff >> FRAC_BITS;
		up_c    = (up_sh > BSW'(UPPER_MAX)) ? UPPER_MAX : UP_W'(up_sh);
		if (ms_s3 > MSW'(mean_s3)) begin
			lo_c = '0;
		end else if (lo_sh > MSW'(LOWER_MAX)) begin
			lo_c = LOWER_MAX;
		end else begin
			lo_c = LO_W'(lo_sh);
		end
	end

	// sequencer, configuration, history and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			win_q       <= WIN_RESET;
			mult_q      <= MULT_RESET;
			wp_q        <= '0;
			cnt_q       <= '0;
			sum_q       <= '0;
			sumsq_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_idx)
					REG_WINDOW: begin
						win_q   <= pwdata[WIN_W-1:0];
						wp_q    <= '0;
						cnt_q   <= '0;
						sum_q   <= '0;
						sumsq_q <= '0;
					end
					REG_MULT: mult_q <= pwdata[MULT_W-1:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SQ;
					end
				end
				S_SQ: state_q <= S_UPD;
				S_UPD: begin
					sum_q   <= sum_q - SUMW'(old_s1) + SUMW'(p_q);
					sumsq_q <= sumsq_q - SQW'(oo_s1) + SQW'(pp_s1);
					cnt_q   <= cnt_nxt;
					wp_q    <= (idx_inc >= w_eff) ? '0 : AW'(idx_inc);
					state_q <= (cnt_nxt >= w_eff) ? S_PREP : S_OUT;
				end
				S_PREP: state_q <= S_DIFF;
				S_DIFF: state_q <= S_DIV;
				S_DIV: begin
					if (root_start) begin
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (root_stat.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			p_q    <= close_price;
			idx_q  <= idx_c;
			full_q <= cnt_q >= w_eff;
		end
		if (state_q == S_SQ) begin
			old_s1 <= full_q ? rd_data : '0;
			pp_s1  <= PPW'(p_q) * PPW'(p_q);
			oo_s1  <= full_q ? PPW'(rd_data) * PPW'(rd_data) : '0;
		end
		if (state_q == S_UPD) begin
			// short window: zero result
			res_full_q  <= 1'b0;
			res_mean_q  <= '0;
			res_sigma_q <= '0;
			res_up_q    <= '0;
			res_lo_q    <= '0;
		end
		if (state_q == S_PREP) begin
			nsq_s2 <= DW'(w_eff) * DW'(sumsq_q);
			ss_s2  <= SSW'(sum_q) * SSW'(sum_q);
			m_s2   <= MW'(w_eff) * MW'(w_eff - NW'(1));
		end
		if ((state_q == S_ROOT) && root_stat.done) begin
			mean_s3  <= mean_c;
			sigma_s3 <= sigma_c;
			ms_s3    <= MSW'(mult_q) * MSW'(sigma_c);
		end
		if (state_q == S_FIN) begin
			res_full_q  <= 1'b1;
			res_mean_q  <= mean_s3;
			res_sigma_q <= sigma_s3;
			res_up_q    <= up_c;
			res_lo_q    <= lo_c;
		end
		if (out_load) begin
			out_full_q  <= res_full_q;
			out_mean_q  <= res_mean_q;
			out_sigma_q <= res_sigma_q;
			out_up_q    <= res_up_q;
			out_lo_q    <= res_lo_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign window_full = out_full_q;
	assign mean_value  = out_mean_q;
	assign sigma_value = out_sigma_q;
	assign upper_band  = out_up_q;
	assign lower_band  = out_lo_q;

`ifndef SYNTHESIS
	a_cnt_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= w_eff)
		else $error("sample count beyond window");

	a_wp_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		NW'(wp_q) < w_eff)
		else $error("write pointer beyond window");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !window_full) |-> (mean_value == '0 && sigma_value == '0
			&& upper_band == '0 && lower_band == '0))
		else $error("short window word carries values");

	a_band_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (UP_W'(lower_band) <= upper_band))
		else $error("lower band above upper band");
`endif

endmodule

FILE: verif/tb_moving_window_bollinger_band_core.sv
// Self-checking testbench for moving_window_bollinger_band_core.
// Holds its own band predictor and drives prices under valid/ready backpressure.
// Depends on mwbb_pkg and the core RTL only.
module tb_moving_window_bollinger_band_core;
	timeunit 1ns;
	timeprecision 1ps;

	import mwbb_pkg::*;

	localparam int PRICE_W     = PRICE_BITS_DEF;
	localparam int FRAC        = FRAC_BITS_DEF;
	localparam int WIN_MAX     = MAX_WINDOW_DEF;
	// allow for a word's processing time plus long output stalls
	localparam int STALL_LIMIT = 20000;
	localparam int SHOW_MAX    = 10;

	// one expected output word
	typedef struct {
		logic            full;
		logic [OUT_W-1:0] mean;
		logic [OUT_W-1:0] sigma;
		logic [UP_W-1:0]  upper;
		logic [LO_W-1:0]  lower;
	} band_word_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                in_valid;
	logic                in_ready;
	logic [PRICE_W-1:0]  close_price;
	logic                out_valid;
	logic                out_ready;
	logic                window_full;
	logic [OUT_W-1:0]    mean_value;
	logic [OUT_W-1:0]    sigma_value;
	logic [UP_W-1:0]     upper_band;
	logic [LO_W-1:0]     lower_band;

	moving_window_bollinger_band_core DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .close_price(close_price),
		.out_valid(out_valid), .out_ready(out_ready), .window_full(window_full),
		.mean_value(mean_value), .sigma_value(sigma_value),
		.upper_band(upper_band), .lower_band(lower_band)
	);

	// predictor copy of the block's registers and history
	logic [WIN_W-1:0]   win_len;
	logic [MULT_W-1:0]  band_mult;
	logic [PRICE_W-1:0] hist_ring [WIN_MAX];
	int unsigned        hist_ptr;
	int unsigned        hist_cnt;
	logic [63:0]        win_sum;
	logic [63:0]        win_sq_sum;

	band_word_t pending_bands[$];
	int         mismatches;
	int         send_idle_pct;
	int         recv_idle_pct;
	int         quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] bitv;
		res  = 64'd0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 64'd0) begin
			if (x >= res + bitv) begin
				x   = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// advances the predicted history by one price and returns the expected word
	function automatic band_word_t next_bands(input logic [PRICE_W-1:0] price);
		band_word_t  b;
		int unsigned w;
		int unsigned idx;
		logic [63:0] p, old, n, d, q, r, m, v, mean, sigma, ms, up, lo;
		// out-of-range window lengths are clamped
		w = (win_len < 2) ? 2 : (win_len > WIN_MAX) ? WIN_MAX : win_len;
		idx = hist_ptr;
		if (idx >= w)
			idx = 0;
		p = 64'(price);
		if (hist_cnt >= w) begin
			old        = 64'(hist_ring[idx]);
			win_sum    = win_sum - old;
			win_sq_sum = win_sq_sum - old * old;
			hist_cnt   = w;
		end else begin
			hist_cnt++;
		end
		hist_ring[idx] = price;
		win_sum    = win_sum + p;
		win_sq_sum = win_sq_sum + p * p;
		hist_ptr   = (idx + 1 >= w) ? 0 : idx + 1;
		b = '{full: 1'b0, mean: '0, sigma: '0, upper: '0, lower: '0};
		// window still filling: all fields zero
		if (hist_cnt < w)
			return b;
		n    = 64'(w);
		mean = (win_sum << FRAC) / n;
		if (mean > 64'(WORD_MAX))
			mean = 64'(WORD_MAX);
		d = n * win_sq_sum;
		q = win_sum * win_sum;
		d = (d >= q) ? d - q : 64'd0;
		m = n * (n - 64'd1);
		q = d / m;
		r = d % m;
		// 64-bit wrap on the shifted quotient is part of the behavior
		v = (q << (2 * FRAC)) + ((r << (2 * FRAC)) / m);
		sigma = int_sqrt(v);
		if (sigma > 64'(WORD_MAX))
			sigma = 64'(WORD_MAX);
		ms = 64'(band_mult) * sigma;
		up = (mean + ms) >> FRAC;
		if (up > 64'(UPPER_MAX))
			up = 64'(UPPER_MAX);
		lo = (ms > mean) ? 64'd0 : ((mean - ms) >> FRAC);
		if (lo > 64'(LOWER_MAX))
			lo = 64'(LOWER_MAX);
		b.full  = 1'b1;
		b.mean  = mean[OUT_W-1:0];
		b.sigma = sigma[OUT_W-1:0];
		b.upper = up[UP_W-1:0];
		b.lower = lo[LO_W-1:0];
		return b;
	endfunction

	// output side: random backpressure, compare each accepted word
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		band_word_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_bands.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOW_MAX)
					$display("unexpected word: full=%0d mean=%0d sigma=%0d up=%0d lo=%0d",
						window_full, mean_value, sigma_value, upper_band, lower_band);
			end else begin
				e = pending_bands.pop_front();
				if (e.full !== window_full || e.mean !== mean_value ||
					e.sigma !== sigma_value || e.upper !== upper_band ||
					e.lower !== lower_band) begin
					mismatches++;
					if (mismatches <= SHOW_MAX) begin
						$display("mismatch exp: full=%0d mean=%0d sigma=%0d up=%0d lo=%0d",
							e.full, e.mean, e.sigma, e.upper, e.lower);
						$display("         got: full=%0d mean=%0d sigma=%0d up=%0d lo=%0d",
							window_full, mean_value, sigma_value, upper_band, lower_band);
					end
				end
			end
		end
	end

	// watchdog: cycles without any handshake on either channel or the config port
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(psel && penable && pwrite))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
				$display("tb_moving_window_bollinger_band_core: done, errors");
				$finish;
			end
		end
	end

	// APB write, setup then access phase; predictor follows since the block is idle
	task automatic reg_write(input reg_idx_t r, input logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({r, 2'b00});
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (r == REG_WINDOW) begin
			win_len    = value[WIN_W-1:0];
			hist_ptr   = 0;
			hist_cnt   = 0;
			win_sum    = '0;
			win_sq_sum = '0;
		end else begin
			band_mult = value[MULT_W-1:0];
		end
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_price(input logic [PRICE_W-1:0] price);
		int gap;
		gap = 0;
		if ($urandom_range(99) < send_idle_pct)
			gap = $urandom_range(6, 1);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		close_price <= price;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_bands.insert(pending_bands.size(), next_bands(price));
		@(negedge clk);
	endtask

	// drop valid, let all words drain, then leave margin for the block to settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_bands.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// upper data bits are random junk half of the time
	task automatic set_regs(input logic [WIN_W-1:0] w, input logic [MULT_W-1:0] m);
		logic [PDATA_W-1:0] junk;
		junk = ($urandom_range(1) != 0) ? PDATA_W'($urandom()) : '0;
		drain();
		reg_write(REG_WINDOW, {junk[PDATA_W-1:WIN_W], w});
		reg_write(REG_MULT, {junk[PDATA_W-1:MULT_W], m});
	endtask

	function automatic logic [PRICE_W-1:0] random_price();
		case ($urandom_range(4))
			0: return PRICE_W'($urandom);
			1: return PRICE_W'($urandom_range(255));
			2: return {PRICE_W{1'b1}} - PRICE_W'($urandom_range(255));
			3: return PRICE_W'(24'd100000 + $urandom_range(2000));
			default: return $urandom_range(1) ? {PRICE_W{1'b1}} : '0;
		endcase
	endfunction

	// reset defaults: window 21, multiplier 2; shows the zero words while filling
	task automatic test_defaults();
		repeat (5) send_price(random_price());
	endtask

	// shortest window, extreme prices, largest multiplier: both bands saturate
	task automatic test_extremes();
		set_regs(6'd2, 3'd7);
		send_price({PRICE_W{1'b1}});
		send_price('0);
		send_price({PRICE_W{1'b1}});
		send_price({PRICE_W{1'b1}});
		send_price('0);
	endtask

	// constant prices give zero sigma; multiplier zero collapses the bands
	task automatic test_flat_window();
		set_regs(6'd3, 3'd0);
		repeat (4) send_price(24'd12345);
		send_price(24'd1);
	endtask

	// window lengths 0 and 1 act as 2
	task automatic test_short_clamp();
		set_regs(6'd0, 3'd4);
		send_price(24'd10);
		send_price(24'd20);
		set_regs(6'd1, 3'd5);
		send_price(24'd7);
		send_price(24'd900);
		send_price(24'h800000);
	endtask

	// random phases; window 0,1 and above 32 exercise clamping
	task automatic test_random(input int sidle, input int ridle, input int items);
		int sent;
		int w;
		int len;
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		sent = 0;
		while (sent < items) begin
			case ($urandom_range(7))
				0: w = 2;
				1: w = WIN_MAX;
				2: w = $urandom_range(63, 33);
				3: w = $urandom_range(1);
				default: w = $urandom_range(12, 2);
			endcase
			if ($urandom_range(3) == 0) begin
				// multiplier change alone keeps the history
				drain();
				reg_write(REG_MULT, PDATA_W'($urandom_range(7)));
			end else begin
				set_regs(WIN_W'(w), MULT_W'($urandom_range(7)));
			end
			len = (w > WIN_MAX ? WIN_MAX : w) + $urandom_range(40, 5);
			repeat (len) send_price(random_price());
			sent += len;
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		in_valid    = 1'b0;
		close_price = '0;
		out_ready   = 1'b0;
		mismatches  = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		win_len    = WIN_RESET;
		band_mult  = MULT_RESET;
		hist_ptr   = 0;
		hist_cnt   = 0;
		win_sum    = '0;
		win_sq_sum = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 11;
		recv_idle_pct = 88;
		test_defaults();
		test_extremes();
		test_flat_window();
		test_short_clamp();

		test_random(11, 88, 490);
		test_random(88, 11, 490);
		test_random(0, 0, 490);

		drain();
		repeat (200) @(negedge clk);
		if (mismatches == 0 && pending_bands.size() == 0)
			$display("tb_moving_window_bollinger_band_core: done, clean");
		else
			$display("tb_moving_window_bollinger_band_core: done, errors");
		$finish;
	end

endmodule
